// File: hw/rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants of the preamble-synchronised serial framer.
// ----------------------------------------------------------------------------
package psf_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TURN    = 3'd1,
        PH_RX_PRE  = 3'd2,
        PH_RX_DATA = 3'd3,
        PH_RX_POST = 3'd4,
        PH_TX_PRE  = 3'd5,
        PH_TX_DATA = 3'd6,
        PH_TX_POST = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_EXPIRY = 2'd1,
        CMD_SEND   = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        REG_BIT_PERIOD      = 2'd0,
        REG_TURNAROUND      = 2'd1,
        REG_CHECK_POSTAMBLE = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hAA;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'h55;
    localparam logic [6:0] EDGES_SUMMED   = 7'd4;
    localparam logic [6:0] ARMED          = 7'd5;
    localparam logic [6:0] BYTE_BITS      = 7'd8;
    localparam int unsigned PHASE_SHIFT   = 3;

    typedef struct packed {
        logic [15:0] bit_period;
        logic [23:0] turnaround_delay;
        logic        check_postamble;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  link_state;
        logic        send_accepted;
        logic [63:0] rx_datagram;
        logic        rx_valid;
        logic        edge_enable;
        logic        timer_enable;
        logic [23:0] timer_value;
        logic        timer_load;
        logic        tx_line;
    } result_t;

endpackage

// File: hw/rtl/preamble_synced_serial_framer.sv
// ----------------------------------------------------------------------------
// preamble_synced_serial_framer
// Half-duplex bit-serial link framer driven by edge, expiry and send requests.
// ----------------------------------------------------------------------------
// Each input request produces exactly one result, registered in the cycle after
// acceptance. A request is taken every cycle while the result register is
// empty or being drained, so throughput is one request per clock and is set
// only by the single result register on the master side. Configuration
// writes are taken at any time and act on the next request; write them only
// while the link is idle. No start-up clearing is needed after reset.
module preamble_synced_serial_framer #(
    parameter int unsigned DATAGRAM_WORDS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // capture_count[15:0], line_level[16], tx_datagram[80:17]
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // tx_line[0], timer_load[1], timer_value[25:2],
                                    // timer_enable[26], edge_enable[27], rx_valid[28],
                                    // rx_datagram[92:29], send_accepted[93],
                                    // link_state[96:94]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    psf_pkg::cfg_t    cfg_reg;
    psf_pkg::result_t result;
    logic             m_tvalid_reg;
    logic [103:0]     m_tdata_reg;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period       <= 16'd6000;
            cfg_reg.turnaround_delay <= 24'd300000;
            cfg_reg.check_postamble  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psf_pkg::REG_BIT_PERIOD:      cfg_reg.bit_period       <= cfg_data[15:0];
                psf_pkg::REG_TURNAROUND:      cfg_reg.turnaround_delay <= cfg_data;
                psf_pkg::REG_CHECK_POSTAMBLE: cfg_reg.check_postamble  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    psf_core #(
        .DATAGRAM_WORDS (DATAGRAM_WORDS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .command       (s_tuser),
        .capture_count (s_tdata[15:0]),
        .line_level    (s_tdata[16]),
        .tx_datagram   (s_tdata[80:17]),
        .cfg           (cfg_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // hold the result until the master side takes it
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_tdata_reg <= {7'd0, result};
        end
    end

endmodule

// File: hw/rtl/psf_core.sv
// ----------------------------------------------------------------------------
// psf_core
// Link state and per-event update: one accepted request is processed per cycle.
// ----------------------------------------------------------------------------
module psf_core #(
    parameter int unsigned DATAGRAM_WORDS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      command,
    input  logic [15:0]     capture_count,
    input  logic            line_level,
    input  logic [63:0]     tx_datagram,
    input  psf_pkg::cfg_t   cfg,
    output psf_pkg::result_t result
);

    localparam logic [6:0] DATA_BITS = 7'(16 * DATAGRAM_WORDS);

    psf_pkg::phase_t phase_reg, phase_next;
    logic [6:0]  bit_index_reg, bit_index_next;
    logic [17:0] pulse_sum_reg, pulse_sum_next;
    logic [63:0] shift_store_reg, shift_store_next;
    logic [7:0]  post_bits_reg, post_bits_next;
    logic        tx_line_reg, tx_line_next;

    logic [6:0]  idx_inc;
    logic [5:0]  bit_pos;
    logic        tx_set;
    logic        tx_level;
    logic        tload;
    logic [23:0] tval;
    logic        rxv;
    logic        accepted;
    logic        ten;
    logic        een;

    assign idx_inc = bit_index_reg + 7'd1;
    assign bit_pos = 6'd63 - bit_index_reg[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= psf_pkg::PH_IDLE;
            bit_index_reg   <= '0;
            pulse_sum_reg   <= '0;
            shift_store_reg <= '0;
            post_bits_reg   <= '0;
            tx_line_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            pulse_sum_reg   <= pulse_sum_next;
            shift_store_reg <= shift_store_next;
            post_bits_reg   <= post_bits_next;
            tx_line_reg     <= tx_line_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        pulse_sum_next   = pulse_sum_reg;
        shift_store_next = shift_store_reg;
        post_bits_next   = post_bits_reg;
        tx_set           = 1'b0;
        tx_level         = 1'b0;
        tload            = 1'b0;
        tval             = '0;
        rxv              = 1'b0;
        accepted         = 1'b0;

        case (command)
            psf_pkg::CMD_EDGE:
            begin
                if (phase_reg inside {psf_pkg::PH_IDLE, psf_pkg::PH_TURN})
                begin
                    // start preamble timing, timeout at two bit periods
                    phase_next       = psf_pkg::PH_RX_PRE;
                    bit_index_next   = '0;
                    pulse_sum_next   = '0;
                    shift_store_next = '0;
                    post_bits_next   = '0;
                    tload            = 1'b1;
                    tval             = {7'd0, cfg.bit_period, 1'b0};
                end
                else if (phase_reg == psf_pkg::PH_RX_PRE)
                begin
                    if (bit_index_reg < psf_pkg::EDGES_SUMMED)
                    begin
                        pulse_sum_next = pulse_sum_reg + {2'd0, capture_count};
                        bit_index_next = idx_inc;
                    end
                    else if (bit_index_reg == psf_pkg::EDGES_SUMMED)
                    begin
                        // mid-bit phase: sum of four counts over eight
                        pulse_sum_next = pulse_sum_reg >> psf_pkg::PHASE_SHIFT;
                        bit_index_next = psf_pkg::ARMED;
                    end
                end
            end
            psf_pkg::CMD_EXPIRY:
            begin
                case (phase_reg)
                    psf_pkg::PH_RX_PRE:
                    begin
                        if (bit_index_reg == psf_pkg::ARMED)
                        begin
                            phase_next     = psf_pkg::PH_RX_DATA;
                            bit_index_next = '0;
                            tload          = 1'b1;
                            tval           = {6'd0, pulse_sum_reg};
                        end
                    end
                    psf_pkg::PH_RX_DATA:
                    begin
                        if (line_level)
                        begin
                            shift_store_next = shift_store_reg | (64'd1 << bit_pos);
                        end
                        bit_index_next = idx_inc;
                        if (idx_inc >= DATA_BITS)
                        begin
                            phase_next     = psf_pkg::PH_RX_POST;
                            bit_index_next = '0;
                        end
                    end
                    psf_pkg::PH_RX_POST:
                    begin
                        if (bit_index_reg < psf_pkg::BYTE_BITS)
                        begin
                            if (line_level)
                            begin
                                post_bits_next = post_bits_reg
                                    | (8'h80 >> bit_index_reg[2:0]);
                            end
                            bit_index_next = idx_inc;
                        end
                        else
                        begin
                            // drop on bad postamble only when checking is on
                            rxv = !cfg.check_postamble
                                || (post_bits_reg == psf_pkg::POSTAMBLE_BYTE);
                            phase_next     = psf_pkg::PH_IDLE;
                            bit_index_next = '0;
                        end
                    end
                    psf_pkg::PH_TURN:
                    begin
                        phase_next = psf_pkg::PH_IDLE;
                    end
                    psf_pkg::PH_TX_PRE:
                    begin
                        tx_set         = 1'b1;
                        tx_level       = psf_pkg::PREAMBLE_BYTE[3'd7 - bit_index_reg[2:0]];
                        bit_index_next = idx_inc;
                        if (idx_inc >= psf_pkg::BYTE_BITS)
                        begin
                            phase_next     = psf_pkg::PH_TX_DATA;
                            bit_index_next = '0;
                        end
                    end
                    psf_pkg::PH_TX_DATA:
                    begin
                        tx_set         = 1'b1;
                        tx_level       = shift_store_reg[bit_pos];
                        bit_index_next = idx_inc;
                        if (idx_inc >= DATA_BITS)
                        begin
                            phase_next     = psf_pkg::PH_TX_POST;
                            bit_index_next = '0;
                        end
                    end
                    psf_pkg::PH_TX_POST:
                    begin
                        tx_set         = 1'b1;
                        bit_index_next = idx_inc;
                        if (bit_index_reg < psf_pkg::BYTE_BITS)
                        begin
                            tx_level = psf_pkg::POSTAMBLE_BYTE[3'd7 - bit_index_reg[2:0]];
                        end
                        else
                        begin
                            // line low, then quiet time before the link frees up
                            tx_level       = 1'b0;
                            phase_next     = psf_pkg::PH_TURN;
                            bit_index_next = '0;
                            tload          = 1'b1;
                            tval           = cfg.turnaround_delay;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            psf_pkg::CMD_SEND:
            begin
                if (phase_reg == psf_pkg::PH_IDLE)
                begin
                    accepted         = 1'b1;
                    phase_next       = psf_pkg::PH_TX_PRE;
                    bit_index_next   = '0;
                    shift_store_next = tx_datagram;
                    tload            = 1'b1;
                    tval             = {8'd0, cfg.bit_period};
                end
            end
            default:
            begin
            end
        endcase

        // the pin holds its last driven level between expiries
        if (tx_set)
        begin
            tx_line_next = tx_level;
        end
        else if (accepted)
        begin
            tx_line_next = 1'b0;
        end
        else
        begin
            tx_line_next = tx_line_reg;
        end
        if (!(phase_next inside {psf_pkg::PH_TX_PRE, psf_pkg::PH_TX_DATA,
                                 psf_pkg::PH_TX_POST}))
        begin
            tx_line_next = 1'b0;
        end

        case (phase_next)
            psf_pkg::PH_IDLE:
            begin
                ten = 1'b0;
                een = 1'b1;
            end
            psf_pkg::PH_TURN:
            begin
                ten = 1'b1;
                een = 1'b1;
            end
            psf_pkg::PH_RX_PRE:
            begin
                ten = (bit_index_next == psf_pkg::ARMED);
                een = (bit_index_next != psf_pkg::ARMED);
            end
            default:
            begin
                ten = 1'b1;
                een = 1'b0;
            end
        endcase

        result.tx_line       = tx_line_next;
        result.timer_load    = tload;
        result.timer_value   = tval;
        result.timer_enable  = ten;
        result.edge_enable   = een;
        result.rx_valid      = rxv;
        result.rx_datagram   = rxv ? shift_store_reg : 64'd0;
        result.send_accepted = accepted;
        result.link_state    = phase_next;
    end

endmodule

// File: hw/rtl/psf_checker.sv
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks of the serial framer, bound to the top level.
// ----------------------------------------------------------------------------
module psf_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // one result follows every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("psf: accepted request produced no result");

    // a waiting result blocks new requests while it is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("psf: request taken over a stalled result");

    // a delivered datagram always leaves the link idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[28]) |-> (m_tdata[96:94] == psf_pkg::PH_IDLE))
        else $error("psf: datagram delivered outside idle");

    // an accepted send always starts the preamble with a timer reload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[93])
            |-> (m_tdata[96:94] == psf_pkg::PH_TX_PRE && m_tdata[1] && !m_tdata[0]))
        else $error("psf: send accepted without preamble start");

    // no timer value without a reload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[25:2] == 24'd0))
        else $error("psf: timer value without reload");

endmodule

bind preamble_synced_serial_framer psf_checker u_psf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the preamble-synchronised serial framer. A short
// table of directed requests is followed by random receive and transmit
// frames, broken frames and noise under several register settings. Each
// status is checked field by field against the link predictor or table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int    WORDS        = 4;
    localparam int    DATA_BITS    = 16 * WORDS;
    localparam int    RX_STEPS     = 80;         // start, 4 counted, arm, load, data, post, deliver
    localparam int    TX_EXPIRIES  = 8 + DATA_BITS + 9;
    localparam int    PHASE_EVENTS = 225;
    localparam int    HOLD_CYCLES  = 150;
    localparam int    CYCLE_LIMIT  = 500000;
    localparam int    PRINT_LIMIT  = 40;

    typedef struct packed {
        psf_pkg::command_t cmd;
        logic [15:0]       tcount;
        logic              level;
        logic [63:0]       dgram;
        logic              typed;
        psf_pkg::result_t  want;
    } probe_t;

    // link_state, send_accepted, rx_datagram, rx_valid, edge_enable,
    // timer_enable, timer_value, timer_load, tx_line
    localparam psf_pkg::result_t PREDICT    = '0;
    localparam psf_pkg::result_t QUIET_IDLE = {psf_pkg::PH_IDLE, 1'b0, 64'd0, 1'b0, 1'b1,
                                               1'b0, 24'd0, 1'b0, 1'b0};
    localparam psf_pkg::result_t RX_START   = {psf_pkg::PH_RX_PRE, 1'b0, 64'd0, 1'b0, 1'b1,
                                               1'b0, 24'd12000, 1'b1, 1'b0};
    localparam psf_pkg::result_t RX_LOCKED  = {psf_pkg::PH_RX_DATA, 1'b0, 64'd0, 1'b0, 1'b0,
                                               1'b1, 24'd32767, 1'b1, 1'b0};

    localparam probe_t PROBES [15] = '{
        {psf_pkg::CMD_NONE,   16'h0000, 1'b0, 64'h0, 1'b1, QUIET_IDLE},
        {psf_pkg::CMD_EXPIRY, 16'h0000, 1'b1, 64'h0, 1'b1, QUIET_IDLE},
        {psf_pkg::CMD_EDGE,   16'h0000, 1'b0, 64'h0, 1'b1, RX_START},
        {psf_pkg::CMD_EXPIRY, 16'h0000, 1'b1, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_NONE,   16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'hFFFF, 1'b0, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'hFFFF, 1'b1, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'hFFFF, 1'b0, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'hFFFF, 1'b1, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'h1234, 1'b0, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_EDGE,   16'h4321, 1'b0, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_SEND,   16'h0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, PREDICT},
        {psf_pkg::CMD_EXPIRY, 16'h0000, 1'b1, 64'h0, 1'b1, RX_LOCKED},
        {psf_pkg::CMD_EDGE,   16'hFFFF, 1'b1, 64'h0, 1'b0, PREDICT},
        {psf_pkg::CMD_SEND,   16'h0000, 1'b1, 64'h8000_0000_0000_0001, 1'b0, PREDICT}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [87:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [103:0]         m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    psf_pkg::reg_index_t  cfg_index;
    logic [23:0]          cfg_data;

    // predictor state and register copies
    psf_pkg::phase_t      link_phase;
    logic [6:0]           link_index;
    logic [17:0]          link_sum;
    logic [63:0]          link_shift;
    logic [7:0]           link_post;
    logic [15:0]          period_ticks;
    logic [23:0]          quiet_ticks;
    logic                 post_check;

    psf_pkg::result_t     pending_status [$];
    int                   mismatch_count;
    int                   results_seen;
    int                   events_sent;
    int                   burst_left;
    int                   cycles;
    bit                   hold_request;

    preamble_synced_serial_framer #(
        .DATAGRAM_WORDS (WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_link();
        link_phase   = psf_pkg::PH_IDLE;
        link_index   = '0;
        link_sum     = '0;
        link_shift   = '0;
        link_post    = '0;
        period_ticks = 16'd6000;
        quiet_ticks  = 24'd300000;
        post_check   = 1'b0;
    endfunction

    // Work out the status after one request and advance the link state.
    function automatic psf_pkg::result_t advance_link(input psf_pkg::command_t cmd,
                                                      input logic [15:0] tcount,
                                                      input logic level,
                                                      input logic [63:0] dgram);
        psf_pkg::result_t r;
        logic             tx_set;
        logic             tx_level;
        int               k;
        r        = '0;
        tx_set   = 1'b0;
        tx_level = 1'b0;
        k        = link_index;
        case (cmd)
            psf_pkg::CMD_EDGE:
            begin
                if (link_phase == psf_pkg::PH_IDLE || link_phase == psf_pkg::PH_TURN)
                begin
                    link_phase    = psf_pkg::PH_RX_PRE;
                    link_index    = '0;
                    link_sum      = '0;
                    link_shift    = '0;
                    link_post     = '0;
                    r.timer_load  = 1'b1;
                    r.timer_value = {7'd0, period_ticks, 1'b0};
                end
                else if (link_phase == psf_pkg::PH_RX_PRE)
                begin
                    if (link_index < psf_pkg::EDGES_SUMMED)
                    begin
                        link_sum   = link_sum + {2'd0, tcount};
                        link_index = link_index + 7'd1;
                    end
                    else if (link_index == psf_pkg::EDGES_SUMMED)
                    begin
                        link_sum   = link_sum >> psf_pkg::PHASE_SHIFT;
                        link_index = psf_pkg::ARMED;
                    end
                end
            end
            psf_pkg::CMD_EXPIRY:
            begin
                case (link_phase)
                    psf_pkg::PH_RX_PRE:
                    begin
                        if (link_index == psf_pkg::ARMED)
                        begin
                            link_phase    = psf_pkg::PH_RX_DATA;
                            link_index    = '0;
                            r.timer_load  = 1'b1;
                            r.timer_value = {6'd0, link_sum};
                        end
                    end
                    psf_pkg::PH_RX_DATA:
                    begin
                        if (k < 64 && level)
                            link_shift[63 - k] = 1'b1;
                        link_index = link_index + 7'd1;
                        if (link_index >= DATA_BITS)
                        begin
                            link_phase = psf_pkg::PH_RX_POST;
                            link_index = '0;
                        end
                    end
                    psf_pkg::PH_RX_POST:
                    begin
                        if (link_index < psf_pkg::BYTE_BITS)
                        begin
                            if (level)
                                link_post[7 - k] = 1'b1;
                            link_index = link_index + 7'd1;
                        end
                        else
                        begin
                            if (!post_check || link_post == psf_pkg::POSTAMBLE_BYTE)
                            begin
                                r.rx_valid    = 1'b1;
                                r.rx_datagram = link_shift;
                            end
                            link_phase = psf_pkg::PH_IDLE;
                            link_index = '0;
                        end
                    end
                    psf_pkg::PH_TURN:
                        link_phase = psf_pkg::PH_IDLE;
                    psf_pkg::PH_TX_PRE:
                    begin
                        tx_set     = 1'b1;
                        tx_level   = psf_pkg::PREAMBLE_BYTE[7 - (k % 8)];
                        link_index = link_index + 7'd1;
                        if (link_index >= psf_pkg::BYTE_BITS)
                        begin
                            link_phase = psf_pkg::PH_TX_DATA;
                            link_index = '0;
                        end
                    end
                    psf_pkg::PH_TX_DATA:
                    begin
                        tx_set     = 1'b1;
                        tx_level   = (k < 64) ? link_shift[63 - k] : 1'b0;
                        link_index = link_index + 7'd1;
                        if (link_index >= DATA_BITS)
                        begin
                            link_phase = psf_pkg::PH_TX_POST;
                            link_index = '0;
                        end
                    end
                    psf_pkg::PH_TX_POST:
                    begin
                        tx_set     = 1'b1;
                        tx_level   = (k < 8) ? psf_pkg::POSTAMBLE_BYTE[7 - k] : 1'b0;
                        link_index = link_index + 7'd1;
                        if (link_index >= 7'd9)
                        begin
                            tx_level      = 1'b0;
                            link_phase    = psf_pkg::PH_TURN;
                            link_index    = '0;
                            r.timer_load  = 1'b1;
                            r.timer_value = quiet_ticks;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            psf_pkg::CMD_SEND:
            begin
                if (link_phase == psf_pkg::PH_IDLE)
                begin
                    r.send_accepted = 1'b1;
                    link_phase      = psf_pkg::PH_TX_PRE;
                    link_index      = '0;
                    link_shift      = dgram;
                    r.timer_load    = 1'b1;
                    r.timer_value   = {8'd0, period_ticks};
                end
            end
            default:
            begin
            end
        endcase

        // hold the level of the bit last sent when no expiry drove the pin
        if (!tx_set)
        begin
            k = link_index;
            case (link_phase)
                psf_pkg::PH_TX_PRE:
                    tx_level = (k == 0 || k > 8) ? 1'b0 : psf_pkg::PREAMBLE_BYTE[8 - k];
                psf_pkg::PH_TX_DATA:
                    if (k == 0)
                        tx_level = psf_pkg::PREAMBLE_BYTE[0];
                    else
                        tx_level = (k > 64) ? 1'b0 : link_shift[64 - k];
                psf_pkg::PH_TX_POST:
                    if (k == 0)
                        tx_level = link_shift[64 - DATA_BITS];
                    else
                        tx_level = (k <= 8) ? psf_pkg::POSTAMBLE_BYTE[8 - k] : 1'b0;
                default:
                    tx_level = 1'b0;
            endcase
        end

        case (link_phase)
            psf_pkg::PH_IDLE:
            begin
                r.timer_enable = 1'b0;
                r.edge_enable  = 1'b1;
            end
            psf_pkg::PH_TURN:
            begin
                r.timer_enable = 1'b1;
                r.edge_enable  = 1'b1;
            end
            psf_pkg::PH_RX_PRE:
            begin
                r.timer_enable = (link_index == psf_pkg::ARMED);
                r.edge_enable  = (link_index != psf_pkg::ARMED);
            end
            default:
            begin
                r.timer_enable = 1'b1;
                r.edge_enable  = 1'b0;
            end
        endcase
        r.tx_line    = tx_level;
        r.link_state = link_phase;
        return r;
    endfunction

    function automatic logic [63:0] pick_datagram();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'hAAAA_5555_AAAA_5555;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("status %0d: %s is %h, should be %h", results_seen, field, got, want);
    endtask

    task automatic check_status(input psf_pkg::result_t got);
        psf_pkg::result_t want;
        if (pending_status.size() == 0)
        begin
            report_mismatch("unrequested status", 64'(got.link_state), 64'd0);
            return;
        end
        want = pending_status.pop_front();
        if (got.tx_line !== want.tx_line)
            report_mismatch("tx_line", 64'(got.tx_line), 64'(want.tx_line));
        if (got.timer_load !== want.timer_load)
            report_mismatch("timer_load", 64'(got.timer_load), 64'(want.timer_load));
        if (got.timer_value !== want.timer_value)
            report_mismatch("timer_value", 64'(got.timer_value), 64'(want.timer_value));
        if (got.timer_enable !== want.timer_enable)
            report_mismatch("timer_enable", 64'(got.timer_enable), 64'(want.timer_enable));
        if (got.edge_enable !== want.edge_enable)
            report_mismatch("edge_enable", 64'(got.edge_enable), 64'(want.edge_enable));
        if (got.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", 64'(got.rx_valid), 64'(want.rx_valid));
        if (got.rx_datagram !== want.rx_datagram)
            report_mismatch("rx_datagram", got.rx_datagram, want.rx_datagram);
        if (got.send_accepted !== want.send_accepted)
            report_mismatch("send_accepted", 64'(got.send_accepted), 64'(want.send_accepted));
        if (got.link_state !== want.link_state)
            report_mismatch("link_state", 64'(got.link_state), 64'(want.link_state));
    endtask

    // Offer one request in bursts with random gaps; predict once it is taken.
    task automatic offer_event(input psf_pkg::command_t cmd, input logic [15:0] tcount,
                               input logic level, input logic [63:0] dgram,
                               input logic typed = 1'b0,
                               input psf_pkg::result_t want = '0);
        psf_pkg::result_t predicted;
        int               gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, dgram, level, tcount};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_link(cmd, tcount, level, dgram);
        pending_status.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    // Stray request that must not disturb a frame in progress.
    task automatic offer_noise();
        psf_pkg::command_t cmd;
        case ($urandom_range(0, 2))
            0:       cmd = psf_pkg::CMD_NONE;
            1:       cmd = psf_pkg::CMD_SEND;
            default: cmd = (link_phase == psf_pkg::PH_IDLE || link_phase == psf_pkg::PH_TURN ||
                            link_phase == psf_pkg::PH_RX_PRE) ?
                           psf_pkg::CMD_NONE : psf_pkg::CMD_EDGE;
        endcase
        offer_event(cmd, 16'($urandom), 1'($urandom), pick_datagram());
    endtask

    // Walk the link back to idle with the fewest sensible requests.
    task automatic settle_link();
        while (link_phase != psf_pkg::PH_IDLE)
        begin
            if (link_phase == psf_pkg::PH_RX_PRE && link_index != psf_pkg::ARMED)
                offer_event(psf_pkg::CMD_EDGE, 16'($urandom), 1'($urandom), pick_datagram());
            else
                offer_event(psf_pkg::CMD_EXPIRY, 16'($urandom), 1'($urandom),
                            pick_datagram());
        end
    endtask

    task automatic receive_frame(input logic corrupt, input int cut_at);
        logic [63:0]       payload;
        logic [7:0]        post;
        logic              level;
        psf_pkg::command_t cmd;
        int                s;
        payload = pick_datagram();
        if (!corrupt)
            post = psf_pkg::POSTAMBLE_BYTE;
        else if ($urandom_range(0, 1) == 0)
            post = psf_pkg::POSTAMBLE_BYTE ^ (8'h01 << $urandom_range(0, 7));
        else
            post = 8'($urandom);
        for (s = 0; s < RX_STEPS && s != cut_at; s++)
        begin
            if (s > 0 && $urandom_range(0, 19) == 0)
                offer_noise();
            cmd = (s < 6) ? psf_pkg::CMD_EDGE : psf_pkg::CMD_EXPIRY;
            if (s >= 7 && s < 7 + DATA_BITS)
                level = payload[70 - s];
            else if (s >= 7 + DATA_BITS && s < RX_STEPS - 1)
                level = post[78 - s];
            else
                level = 1'($urandom);
            offer_event(cmd, 16'($urandom), level, pick_datagram());
        end
    endtask

    task automatic send_frame();
        int s;
        offer_event(psf_pkg::CMD_SEND, 16'($urandom), 1'($urandom), pick_datagram());
        for (s = 0; s < TX_EXPIRIES; s++)
        begin
            if ($urandom_range(0, 19) == 0)
                offer_noise();
            offer_event(psf_pkg::CMD_EXPIRY, 16'($urandom), 1'($urandom), pick_datagram());
        end
    endtask

    task automatic run_traffic(input int upto);
        int choice;
        int n;
        while (events_sent < upto)
        begin
            choice = $urandom_range(0, 19);
            if (choice < 8)
            begin
                settle_link();
                receive_frame(1'b0, -1);
            end
            else if (choice < 10)
            begin
                settle_link();
                receive_frame(1'b1, -1);
            end
            else if (choice < 12)
            begin
                settle_link();
                receive_frame(1'($urandom), $urandom_range(1, RX_STEPS - 1));
            end
            else if (choice < 17)
            begin
                settle_link();
                send_frame();
                // abandon the turnaround now and then
                if ($urandom_range(0, 2) == 0)
                    receive_frame(1'b0, -1);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    offer_event(psf_pkg::command_t'($urandom_range(0, 3)), 16'($urandom),
                                1'($urandom), pick_datagram());
            end
        end
    endtask

    task automatic drain_link();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [23:0] period_word, input logic [23:0] quiet,
                                 input logic check);
        psf_pkg::reg_index_t idx [4];
        logic [23:0]         val [4];
        int                  i;
        idx[0] = psf_pkg::REG_BIT_PERIOD;      val[0] = period_word;
        idx[1] = psf_pkg::REG_TURNAROUND;      val[1] = quiet;
        idx[2] = psf_pkg::REG_CHECK_POSTAMBLE; val[2] = {23'($urandom), check};
        idx[3] = psf_pkg::REG_UNUSED;          val[3] = 24'($urandom);
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                psf_pkg::REG_BIT_PERIOD:      period_ticks = val[i][15:0];
                psf_pkg::REG_TURNAROUND:      quiet_ticks  = val[i];
                psf_pkg::REG_CHECK_POSTAMBLE: post_check   = val[i][0];
                default:
                begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Status sink: random stall patterns plus long hold-offs on request.
    initial
    begin : status_sink
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_status(psf_pkg::result_t'(m_tdata[96:0]));
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int          i;
        int          ph;
        logic [23:0] period_word;
        logic [23:0] quiet;
        logic        check;
        mismatch_count = 0;
        results_seen   = 0;
        events_sent    = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        reset_link();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = psf_pkg::CMD_NONE;
        cfg_valid = 1'b0;
        cfg_index = psf_pkg::REG_BIT_PERIOD;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(PROBES); i++)
            offer_event(PROBES[i].cmd, PROBES[i].tcount, PROBES[i].level, PROBES[i].dgram,
                        PROBES[i].typed, PROBES[i].want);
        settle_link();
        drain_link();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    period_word = 24'd1;
                    quiet       = 24'd1;
                    check       = 1'b1;
                end
                1:
                begin
                    period_word = 24'h00FFFF;
                    quiet       = 24'hFFFFFF;
                    check       = 1'b0;
                end
                2:
                begin
                    // zero period with junk in the unused upper bits
                    period_word = {8'($urandom | 1), 16'h0000};
                    quiet       = 24'($urandom);
                    check       = 1'b1;
                end
                3:
                begin
                    period_word = 24'($urandom);
                    quiet       = 24'($urandom);
                    check       = 1'($urandom);
                end
                default:
                begin
                    period_word = 24'd6000;
                    quiet       = 24'd300000;
                    check       = 1'b1;
                end
            endcase
            load_settings(period_word, quiet, check);
            hold_request = 1'b1;
            run_traffic(events_sent + PHASE_EVENTS);
            drain_link();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
